// File: hw/rtl/destination_address_sort_key_core_defines.svh
// Assertion macros shared by the RTL of the destination address sort key core.
// Depends on nothing; files that check their logic include it by name.
`ifndef DESTINATION_ADDRESS_SORT_KEY_CORE_DEFINES_SVH
`define DESTINATION_ADDRESS_SORT_KEY_CORE_DEFINES_SVH

// Checked on every rising edge of clock, suspended while reset is high.
`define DASK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define DASK_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hw/rtl/dask_pkg.sv
// Types, constants and policy values of the destination address sort key core.
// Depends on nothing; the classify, prefix and top-level RTL files refer to it by scoped names.
`default_nettype none

package dask_pkg;

   localparam int unsigned MAX_ADDRESSES = 48;
   localparam int unsigned PREFIX_BYTES  = 16;

   // Bit positions of the fields in the sort key.
   localparam int unsigned KEY_WIDTH      = 31;
   localparam int unsigned KEY_USABLE_BIT = 30;
   localparam int unsigned KEY_SCOPE_BIT  = 29;
   localparam int unsigned KEY_LABEL_BIT  = 28;

   // Policy table: precedence and label values.
   localparam logic [7:0] PREC_LOOPBACK = 8'd50;
   localparam logic [7:0] PREC_V4MAPPED = 8'd35;
   localparam logic [7:0] PREC_6TO4     = 8'd30;
   localparam logic [7:0] PREC_TEREDO   = 8'd5;
   localparam logic [7:0] PREC_ULA      = 8'd3;
   localparam logic [7:0] PREC_DEFAULT  = 8'd40;

   localparam logic [3:0] LABEL_LOOPBACK = 4'd0;
   localparam logic [3:0] LABEL_V4MAPPED = 4'd4;
   localparam logic [3:0] LABEL_6TO4     = 4'd2;
   localparam logic [3:0] LABEL_TEREDO   = 4'd5;
   localparam logic [3:0] LABEL_ULA      = 4'd13;
   localparam logic [3:0] LABEL_DEFAULT  = 4'd1;

   localparam logic [3:0] SCOPE_LINK   = 4'd2;
   localparam logic [3:0] SCOPE_SITE   = 4'd5;
   localparam logic [3:0] SCOPE_GLOBAL = 4'd14;

   localparam logic [31:0] V4MAPPED_TAG = 32'h0000_ffff;

   typedef struct packed {
      logic [7:0] prec;
      logic [3:0] label;
      logic [3:0] scope;
   } class_type;

endpackage

`default_nettype wire

// File: hw/rtl/dask_classify.sv
// Policy table lookup and scope decode for one 128-bit address.
// Depends on dask_pkg for the table values and class_type.
`default_nettype none

module dask_classify (
   input  wire logic [63:0]        addr_high,
   input  wire logic [63:0]        addr_low,
   output dask_pkg::class_type     class_info
);

   logic loopback;

   assign loopback = (addr_high == 64'd0) && (addr_low == 64'd1);

   always_comb begin
      priority if (loopback) begin
         class_info.prec  = dask_pkg::PREC_LOOPBACK;
         class_info.label = dask_pkg::LABEL_LOOPBACK;
      end else if ((addr_high == 64'd0) && (addr_low[63:32] == dask_pkg::V4MAPPED_TAG)) begin
         class_info.prec  = dask_pkg::PREC_V4MAPPED;
         class_info.label = dask_pkg::LABEL_V4MAPPED;
      end else if (addr_high[63:48] == 16'h2002) begin
         class_info.prec  = dask_pkg::PREC_6TO4;
         class_info.label = dask_pkg::LABEL_6TO4;
      end else if (addr_high[63:32] == 32'h2001_0000) begin
         class_info.prec  = dask_pkg::PREC_TEREDO;
         class_info.label = dask_pkg::LABEL_TEREDO;
      end else if (addr_high[63:57] == 7'h7e) begin
         class_info.prec  = dask_pkg::PREC_ULA;
         class_info.label = dask_pkg::LABEL_ULA;
      end else begin
         class_info.prec  = dask_pkg::PREC_DEFAULT;
         class_info.label = dask_pkg::LABEL_DEFAULT;
      end

      // Multicast carries its scope in the low nibble of the second byte.
      priority if (addr_high[63:56] == 8'hff) begin
         class_info.scope = addr_high[51:48];
      end else if (addr_high[63:54] == 10'h3fa) begin
         class_info.scope = dask_pkg::SCOPE_LINK;
      end else if (loopback) begin
         class_info.scope = dask_pkg::SCOPE_LINK;
      end else if (addr_high[63:54] == 10'h3fb) begin
         class_info.scope = dask_pkg::SCOPE_SITE;
      end else begin
         class_info.scope = dask_pkg::SCOPE_GLOBAL;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/dask_prefix.sv
// Common prefix length of two 128-bit addresses, 0 to 128.
// Depends on dask_pkg for the byte count of the search.
`default_nettype none

module dask_prefix (
   input  wire logic [63:0] a_high,
   input  wire logic [63:0] a_low,
   input  wire logic [63:0] b_high,
   input  wire logic [63:0] b_low,
   output logic      [7:0]  prefix_len
);

   logic [127:0] diff;

   function automatic logic [2:0] lead_zeros8(input logic [7:0] value);
      logic [2:0] count;
      count = 3'd0;
      for (int b = 0; b < 8; b++) begin
         if (value[b]) begin
            count = 3'(7 - b);
         end
      end
      return count;
   endfunction

   assign diff = {a_high ^ b_high, a_low ^ b_low};

   // The most significant nonzero byte wins, since it is visited last.
   always_comb begin
      prefix_len = 8'd128;
      for (int i = 0; i < dask_pkg::PREFIX_BYTES; i++) begin
         if (diff[8*i +: 8] != 8'd0) begin
            prefix_len = 8'((dask_pkg::PREFIX_BYTES - 1 - i) * 8)
                       + {5'd0, lead_zeros8(diff[8*i +: 8])};
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/destination_address_sort_key_core.sv
// Top level of the destination address sort key core: input register, key logic,
// result register. Depends on dask_pkg, dask_classify, dask_prefix and the defines header.
//
// Usage: drive the req_ fields and raise start; a transfer takes place at each rising
// edge where start is high and busy is low. busy is high only in the cycle after
// reset, so one candidate can be accepted in every cycle thereafter.
// The key appears on rsp_sort_key with rsp_valid high once the accepted candidate has
// passed the input register and then the result register. Throughput is one candidate
// per cycle, set by the single pass of table match, scope decode and leading-equal-bit
// count between the two registers.
// Each result is shown for exactly one cycle; the receiver cannot stall and must
// take it then. Results come out in the order the candidates were accepted.
// Reset (synchronous, active high) drops any candidate in flight and raises busy
// for one cycle.
`default_nettype none
`include "destination_address_sort_key_core_defines.svh"

module destination_address_sort_key_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_dest_high,
   input  wire logic [63:0] req_dest_low,
   input  wire logic        req_dest_is_ipv4,
   input  wire logic        req_route_found,
   input  wire logic        req_source_found,
   input  wire logic [63:0] req_source_high,
   input  wire logic [63:0] req_source_low,
   input  wire logic [5:0]  req_position,
   output logic             rsp_valid,
   output logic [30:0]      rsp_sort_key
);

   logic        accept;
   logic        busy_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] dest_high_ff, dest_high_in;
   logic [63:0] dest_low_ff, dest_low_in;
   logic [63:0] src_high_ff, src_high_in;
   logic [63:0] src_low_ff, src_low_in;
   logic        route_ff, source_ff;
   logic [5:0]  position_ff;

   logic        rsp_valid_ff;
   logic [30:0] sort_key_ff, sort_key_in;

   dask_pkg::class_type dest_class;
   dask_pkg::class_type src_class;
   logic [7:0]  prefix_len;
   logic        have_source;
   logic [7:0]  order;
   logic [3:0]  inv_scope;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // IPv4 addresses are mapped to ::ffff:a.b.c.d before they are registered.
   always_comb begin
      s1_valid_in = accept;
      if (req_dest_is_ipv4) begin
         dest_high_in = 64'd0;
         dest_low_in  = {dask_pkg::V4MAPPED_TAG, req_dest_low[31:0]};
         src_high_in  = 64'd0;
         src_low_in   = {dask_pkg::V4MAPPED_TAG, req_source_low[31:0]};
      end else begin
         dest_high_in = req_dest_high;
         dest_low_in  = req_dest_low;
         src_high_in  = req_source_high;
         src_low_in   = req_source_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dest_high_ff <= dest_high_in;
         dest_low_ff  <= dest_low_in;
         src_high_ff  <= src_high_in;
         src_low_ff   <= src_low_in;
         route_ff     <= req_route_found;
         source_ff    <= req_source_found;
         position_ff  <= req_position;
      end
      sort_key_ff <= sort_key_in;
   end

   dask_classify u_dest_class (
      .addr_high  (dest_high_ff),
      .addr_low   (dest_low_ff),
      .class_info (dest_class)
   );

   dask_classify u_src_class (
      .addr_high  (src_high_ff),
      .addr_low   (src_low_ff),
      .class_info (src_class)
   );

   dask_prefix u_prefix (
      .a_high     (src_high_ff),
      .a_low      (src_low_ff),
      .b_high     (dest_high_ff),
      .b_low      (dest_low_ff),
      .prefix_len (prefix_len)
   );

   assign have_source = route_ff && source_ff;
   assign inv_scope   = 4'd15 - dest_class.scope;
   assign order       = ({2'd0, position_ff} < 8'(dask_pkg::MAX_ADDRESSES))
                      ? 8'(dask_pkg::MAX_ADDRESSES) - {2'd0, position_ff} : 8'd0;

   always_comb begin
      sort_key_in = '0;
      sort_key_in[dask_pkg::KEY_USABLE_BIT] = route_ff;
      sort_key_in[dask_pkg::KEY_SCOPE_BIT]  = have_source
                                            && (src_class.scope == dest_class.scope);
      sort_key_in[dask_pkg::KEY_LABEL_BIT]  = have_source
                                            && (src_class.label == dest_class.label);
      sort_key_in[27:20] = dest_class.prec;
      sort_key_in[19:16] = inv_scope;
      sort_key_in[15:8]  = have_source ? prefix_len : 8'd0;
      sort_key_in[7:0]   = order;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sort_key = sort_key_ff;

   `DASK_ASSERT_ALWAYS(a_busy_after_reset, reset |=> busy, "busy must follow reset")
   `DASK_ASSERT(a_accept_reaches_result, accept |=> ##1 rsp_valid,
      "an accepted candidate must give a result two cycles later")
   `DASK_ASSERT(a_no_invented_result, rsp_valid |-> $past(s1_valid_ff),
      "a result must come from a registered candidate")
   `DASK_ASSERT(a_prefix_range, rsp_valid |-> (rsp_sort_key[15:8] <= 8'd128),
      "prefix length must not exceed 128")
   `DASK_ASSERT(a_unusable_clean, (rsp_valid && !rsp_sort_key[30]) |->
      (rsp_sort_key[29:28] == 2'b00 && rsp_sort_key[15:8] == 8'd0),
      "an unusable candidate must carry no match bits and no prefix length")

endmodule

`default_nettype wire
